@@ rtl/piecewise_linear_converter_assert.svh @@
// Assertion macros for the converter checker.
// All macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef PIECEWISE_LINEAR_CONVERTER_ASSERT_SVH
`define PIECEWISE_LINEAR_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define PLC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("plc assertion failed");

// Next-cycle implication.
`define PLC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("plc assertion failed");

`endif

@@ rtl/plc_pkg.sv @@
`timescale 1ns / 1ps
package plc_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int DATA_W         = 32;

    localparam logic [1:0] KIND_CONVERT = 2'd0;
    localparam logic [1:0] KIND_ADD     = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    localparam logic CFG_LOWER = 1'b0;
    localparam logic CFG_UPPER = 1'b1;

    typedef enum logic [1:0] {
        OP_CONVERT,
        OP_ADD,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] y_value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] y_result;
        logic                     table_ready;
        logic                     add_rejected;
    } t_out;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] y_value;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] upper;
    } t_limits;

    typedef struct packed {
        logic                    start;
        logic [2*DATA_W-1:0]     dividend;
        logic [DATA_W-1:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic [2*DATA_W-1:0]     quotient;
    } t_div_rsp;

endpackage

@@ rtl/plc_ram.sv @@
`timescale 1ns / 1ps
module plc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/plc_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module plc_div
    import plc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEPS = 2 * DATA_W;
    localparam int CW    = $clog2(STEPS);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [STEPS-1:0]  r_quo;
    logic [DATA_W-1:0] r_div;

    logic [DATA_W:0]   trial;
    logic              ge;
    logic [DATA_W:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_quo[STEPS-1]};
        ge    = trial >= {1'b0, r_div};
        n_rem = ge ? (trial - {1'b0, r_div}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem[DATA_W-1:0];
                r_quo <= {r_quo[STEPS-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ rtl/plc_front.sv @@
`timescale 1ns / 1ps
// Input side: decode the request kind, hold up to two commands.
module plc_front
    import plc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_cmd_valid,
    input  logic i_cmd_ready,
    output t_cmd o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       dec;
    logic       push;
    logic       pop;

    always_comb begin
        dec.x_value = i_in_data.x_value;
        dec.y_value = i_in_data.y_value;
        unique case (i_in_data.kind)
            KIND_CONVERT: dec.op = OP_CONVERT;
            KIND_ADD:     dec.op = OP_ADD;
            KIND_CLEAR:   dec.op = OP_CLEAR;
            default:      dec.op = OP_NOP;
        endcase
    end

    assign o_in_ready  = r_cnt != 2'd2;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd       = r_q[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/plc_back.sv @@
`timescale 1ns / 1ps
// Execution side: table update, segment search, interpolation, clamp.
module plc_back
    import plc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int AW        = $clog2(MAX_POINTS),
    localparam int CNT_W     = $clog2(MAX_POINTS + 1)
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    output logic    o_cmd_ready,
    input  t_cmd    i_cmd,
    input  t_limits i_limits,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out
);

    localparam int VW = DATA_W + 5;
    localparam logic signed [VW-1:0] SAT_HI = VW'(64'sd34359738368);
    localparam logic signed [VW-1:0] SAT_LO = -SAT_HI;
    localparam logic [2*DATA_W-1:0]  Q_MAX  = 64'h0000_0004_0000_0000;

    typedef enum logic [22:0] {
        S_IDLE      = 23'd1 << 0,
        S_ONE_RD    = 23'd1 << 1,
        S_ONE_GET   = 23'd1 << 2,
        S_LAST_RD   = 23'd1 << 3,
        S_LAST_CHK  = 23'd1 << 4,
        S_SCAN_RD   = 23'd1 << 5,
        S_SCAN_CHK  = 23'd1 << 6,
        S_A_RD      = 23'd1 << 7,
        S_B_RD      = 23'd1 << 8,
        S_B_GET     = 23'd1 << 9,
        S_DIFF      = 23'd1 << 10,
        S_MUL       = 23'd1 << 11,
        S_DIV_GO    = 23'd1 << 12,
        S_DIV_WAIT  = 23'd1 << 13,
        S_CLAMP     = 23'd1 << 14,
        S_OUT       = 23'd1 << 15,
        S_INS_RD    = 23'd1 << 16,
        S_INS_CHK   = 23'd1 << 17,
        S_SHIFT_RD  = 23'd1 << 18,
        S_SHIFT_WR  = 23'd1 << 19,
        S_INS_WR    = 23'd1 << 20,
        S_FIRST_RD  = 23'd1 << 21,
        S_FIRST_CHK = 23'd1 << 22
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_k, n_k;
    logic [CNT_W-1:0]         r_i, n_i;
    logic [CNT_W-1:0]         r_j, n_j;
    logic signed [DATA_W-1:0] r_x, n_x;
    logic signed [DATA_W-1:0] r_y, n_y;
    t_point                   r_pa, n_pa;
    t_point                   r_pb, n_pb;
    logic [DATA_W-1:0]        r_mdy, n_mdy;
    logic [DATA_W-1:0]        r_mdxi, n_mdxi;
    logic [DATA_W-1:0]        r_mdx, n_mdx;
    logic                     r_neg, n_neg;
    logic [2*DATA_W-1:0]      r_prod, n_prod;
    logic signed [VW-1:0]     r_val, n_val;
    logic signed [DATA_W-1:0] r_res, n_res;
    logic                     r_rej, n_rej;
    logic                     r_out_valid, n_out_valid;
    t_out                     r_out, n_out;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [AW-1:0]            ram_raddr;
    logic [$bits(t_point)-1:0] ram_wdata;
    logic [$bits(t_point)-1:0] ram_rdata;
    t_point                   rd_pt;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    logic signed [DATA_W:0]   dy, dxi, dx;
    logic [CNT_W-1:0]         i_next;
    logic [CNT_W-1:0]         j_prev;
    logic signed [VW-1:0]     lo_ext, hi_ext;
    logic [VW-1:0]            q_ext;

    assign rd_pt  = t_point'(ram_rdata);
    assign i_next = r_i + 1'b1;
    assign j_prev = r_j - 1'b1;
    assign lo_ext = {{(VW-DATA_W){i_limits.lower[DATA_W-1]}}, i_limits.lower};
    assign hi_ext = {{(VW-DATA_W){i_limits.upper[DATA_W-1]}}, i_limits.upper};

    plc_ram #(
        .WIDTH ($bits(t_point)),
        .DEPTH (MAX_POINTS)
    ) u_plc_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    plc_div u_plc_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_k         = r_k;
        n_i         = r_i;
        n_j         = r_j;
        n_x         = r_x;
        n_y         = r_y;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_mdy       = r_mdy;
        n_mdxi      = r_mdxi;
        n_mdx       = r_mdx;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_val       = r_val;
        n_res       = r_res;
        n_rej       = r_rej;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_cmd_ready = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_i[AW-1:0];
        ram_wdata   = {r_x, r_y};
        ram_raddr   = r_k[AW-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = r_prod;
        div_req.divisor  = r_mdx;
        dy    = {r_pb.y[DATA_W-1], r_pb.y} - {r_pa.y[DATA_W-1], r_pa.y};
        dxi   = {r_x[DATA_W-1], r_x} - {r_pa.x[DATA_W-1], r_pa.x};
        dx    = {r_pb.x[DATA_W-1], r_pb.x} - {r_pa.x[DATA_W-1], r_pa.x};
        q_ext = {2'b00, div_rsp.quotient[DATA_W+2:0]};

        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_x   = i_cmd.x_value;
                    n_y   = i_cmd.y_value;
                    n_res = '0;
                    n_rej = 1'b0;
                    unique case (i_cmd.op)
                        OP_CONVERT: begin
                            if (r_count == '0) begin
                                n_val   = '0;
                                n_state = S_CLAMP;
                            end else if (r_count == CNT_W'(1)) begin
                                n_k     = '0;
                                n_state = S_ONE_RD;
                            end else begin
                                n_k     = r_count - 1'b1;
                                n_state = S_LAST_RD;
                            end
                        end
                        OP_ADD: begin
                            if (r_count == CNT_W'(MAX_POINTS)) begin
                                n_rej   = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                n_k     = '0;
                                n_state = S_INS_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_OUT;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_ONE_RD:  n_state = S_ONE_GET;
            S_ONE_GET: begin
                n_val   = {{(VW-DATA_W){rd_pt.y[DATA_W-1]}}, rd_pt.y};
                n_state = S_CLAMP;
            end
            S_LAST_RD: n_state = S_LAST_CHK;
            S_LAST_CHK: begin
                // at or past the last point: check the first point before
                // extending the last segment
                if (r_x >= rd_pt.x) begin
                    n_k     = '0;
                    n_state = S_FIRST_RD;
                end else begin
                    n_k     = CNT_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_FIRST_RD: n_state = S_FIRST_CHK;
            S_FIRST_CHK: begin
                // at or below the first point the first segment wins
                if (r_x <= rd_pt.x) begin
                    n_i = '0;
                end else begin
                    n_i = r_count - CNT_W'(2);
                end
                n_state = S_A_RD;
            end
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (r_x <= rd_pt.x) begin
                    n_i     = r_k - 1'b1;
                    n_state = S_A_RD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_A_RD: begin
                ram_raddr = r_i[AW-1:0];
                n_state   = S_B_RD;
            end
            S_B_RD: begin
                ram_raddr = i_next[AW-1:0];
                n_pa      = rd_pt;
                n_state   = S_B_GET;
            end
            S_B_GET: begin
                n_pb    = rd_pt;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                if (r_pb.x == r_pa.x) begin
                    n_val   = {{(VW-DATA_W){r_pa.y[DATA_W-1]}}, r_pa.y};
                    n_state = S_CLAMP;
                end else begin
                    n_mdy   = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
                    n_mdxi  = dxi[DATA_W] ? DATA_W'(-dxi) : dxi[DATA_W-1:0];
                    n_mdx   = dx[DATA_W] ? DATA_W'(-dx) : dx[DATA_W-1:0];
                    n_neg   = (dy[DATA_W] ^ dxi[DATA_W] ^ dx[DATA_W])
                              && (dy != '0) && (dxi != '0);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = r_mdy * r_mdxi;
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_req.start = 1'b1;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient > Q_MAX) begin
                        n_val = r_neg ? SAT_LO : SAT_HI;
                    end else if (r_neg) begin
                        n_val = {{(VW-DATA_W){r_pa.y[DATA_W-1]}}, r_pa.y} - $signed(q_ext);
                    end else begin
                        n_val = {{(VW-DATA_W){r_pa.y[DATA_W-1]}}, r_pa.y} + $signed(q_ext);
                    end
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                priority if (r_val < lo_ext) begin
                    n_res = i_limits.lower;
                end else if (r_val > hi_ext) begin
                    n_res = i_limits.upper;
                end else begin
                    n_res = r_val[DATA_W-1:0];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.y_result    = r_res;
                    n_out.table_ready = r_count != '0;
                    n_out.add_rejected = r_rej;
                    n_state           = S_IDLE;
                end
            end
            S_INS_RD: begin
                if (r_k == r_count) begin
                    n_i     = r_count;
                    n_state = S_INS_WR;
                end else begin
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                // new point goes ahead of equal x
                if (rd_pt.x >= r_x) begin
                    n_i     = r_k;
                    n_j     = r_count;
                    n_state = S_SHIFT_RD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_INS_RD;
                end
            end
            S_SHIFT_RD: begin
                ram_raddr = j_prev[AW-1:0];
                if (r_j == r_i) begin
                    n_state = S_INS_WR;
                end else begin
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[AW-1:0];
                ram_wdata = ram_rdata;
                n_j       = j_prev;
                n_state   = S_SHIFT_RD;
            end
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_i[AW-1:0];
                n_count   = r_count + 1'b1;
                n_state   = S_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_k    <= n_k;
        r_i    <= n_i;
        r_j    <= n_j;
        r_x    <= n_x;
        r_y    <= n_y;
        r_pa   <= n_pa;
        r_pb   <= n_pb;
        r_mdy  <= n_mdy;
        r_mdxi <= n_mdxi;
        r_mdx  <= n_mdx;
        r_neg  <= n_neg;
        r_prod <= n_prod;
        r_val  <= n_val;
        r_res  <= n_res;
        r_rej  <= n_rej;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ rtl/piecewise_linear_converter.sv @@
// Convert: table points are checked one by one in the RAM, then a bit-serial
// divide runs; an empty table or a single point skips the search and the divide.
// Add: points are scanned to find the slot, then the later points are moved up.
// Clear and unknown kinds go straight to the output. One request in work at a time; a
// two-entry command queue keeps input accepted while the back end is busy, until the queue is full.
// Reset (sync, active low) empties the table, clears the queue, sets full limits.
`timescale 1ns / 1ps
module piecewise_linear_converter
    import plc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data,
    // configuration writes, only while idle
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);

    // clamp limits, lower tested first
    t_limits r_limits;

    logic    cmd_valid;
    logic    cmd_ready;
    t_cmd    cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.lower <= {1'b1, {(DATA_W-1){1'b0}}};
            r_limits.upper <= {1'b0, {(DATA_W-1){1'b1}}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOWER: r_limits.lower <= i_cfg_data;
                CFG_UPPER: r_limits.upper <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // front: decode kind and queue requests
    plc_front u_plc_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // back: table RAM, segment search, divide, clamp, output register
    plc_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_plc_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_limits    (r_limits),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

@@ rtl/plc_checker.sv @@
`timescale 1ns / 1ps
`include "piecewise_linear_converter_assert.svh"
module plc_checker
    import plc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    `PLC_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `PLC_ASSERT_IMP(a_rej_full, o_out_valid && o_out_data.add_rejected, o_out_data.table_ready)
    `PLC_ASSERT_IMP(a_rej_zero, o_out_valid && o_out_data.add_rejected, o_out_data.y_result == '0)

endmodule

bind piecewise_linear_converter plc_checker u_plc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ tb/piecewise_linear_converter_test.sv @@
`timescale 1ns / 1ps
module piecewise_linear_converter_test;
    import plc_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int LONG_HOLD   = 600;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in               i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out              o_out_data;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic [DATA_W-1:0] i_cfg_data;

    piecewise_linear_converter #(.MAX_POINTS(TABLE_DEPTH)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Predictor state: a private copy of the calibration table and limits.
    logic signed [63:0] cal_x [TABLE_DEPTH];
    logic signed [63:0] cal_y [TABLE_DEPTH];
    int unsigned        cal_count;
    logic signed [63:0] lim_lo;
    logic signed [63:0] lim_hi;

    t_in  pending_requests[$];   // stimulus waiting for the driver
    t_out expected_results[$];   // predicted results, oldest first
    int   mismatch_count;
    int   results_seen;
    int   converts_sent;
    int   rejects_seen;

    // Sender / receiver pacing controls.
    int   burst_left;
    int   gap_left;
    int   stall_mode;
    int   hold_left;
    bit   sender_paused;

    function automatic logic signed [63:0] clamp_to_limits(logic signed [63:0] v);
        if (v < lim_lo) return lim_lo;
        if (v > lim_hi) return lim_hi;
        return v;
    endfunction

    function automatic logic signed [63:0] interpolate(logic signed [63:0] x);
        int unsigned seg;
        logic signed [63:0] xa, ya, xb, yb, dy, dxi, dx;
        logic [63:0] q;
        bit neg;
        if (cal_count == 0) return clamp_to_limits(64'sd0);
        if (cal_count == 1) return clamp_to_limits(cal_y[0]);
        if (x <= cal_x[0]) begin
            seg = 0;
        end else if (x >= cal_x[cal_count-1]) begin
            seg = cal_count - 2;
        end else begin
            seg = 0;
            while (seg + 1 < cal_count && x > cal_x[seg+1]) seg++;
            if (seg + 1 >= cal_count) seg = cal_count - 2;
        end
        xa = cal_x[seg];
        ya = cal_y[seg];
        xb = cal_x[seg+1];
        yb = cal_y[seg+1];
        if (xb == xa) return clamp_to_limits(ya);
        dy  = yb - ya;
        dxi = x - xa;
        dx  = xb - xa;
        neg = ((dy < 0) != (dxi < 0)) != (dx < 0);
        if (dy == 0 || dxi == 0) neg = 1'b0;
        // magnitudes taken unsigned so the 64-bit product cannot go negative
        q = ($unsigned(dy < 0 ? -dy : dy) * $unsigned(dxi < 0 ? -dxi : dxi)) /
            $unsigned(dx < 0 ? -dx : dx);
        // far out of range: saturate before the clamp
        if (q > (64'd1 << 34))
            return clamp_to_limits(neg ? -(64'sd1 <<< 62) : (64'sd1 <<< 62) - 1);
        return clamp_to_limits(neg ? ya - $signed(q) : ya + $signed(q));
    endfunction

    // Advance the predictor by one accepted request.
    function automatic t_out predict_request(t_in req);
        t_out r;
        int unsigned pos;
        r = '0;
        if (req.kind == KIND_CONVERT) begin
            r.y_result = 32'(interpolate(64'(req.x_value)));
        end else if (req.kind == KIND_ADD) begin
            if (cal_count >= TABLE_DEPTH) begin
                r.add_rejected = 1'b1;
            end else begin
                pos = 0;
                while (pos < cal_count && cal_x[pos] < 64'(req.x_value)) pos++;
                for (int j = cal_count; j > pos; j--) begin
                    cal_x[j] = cal_x[j-1];
                    cal_y[j] = cal_y[j-1];
                end
                cal_x[pos] = 64'(req.x_value);
                cal_y[pos] = 64'(req.y_value);
                cal_count++;
            end
        end else if (req.kind == KIND_CLEAR) begin
            cal_count = 0;
        end
        r.table_ready = (cal_count != 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s at %0t: got %h expected %h", what, $time, got, want);
        mismatch_count++;
    endtask

    // Driver: bursts of requests separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_request(i_in_data));
                if (i_in_data.kind == KIND_CONVERT) converts_sent++;
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (sender_paused || pending_requests.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_data  <= pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 :
                                      $urandom_range(1, 60);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Receiver: stall pattern changes now and then; a long hold can be armed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_mode  <= 0;
        end else begin
            if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
                case (stall_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) == 0);
                    2: i_out_ready <= ($urandom_range(0, 7) == 0);
                    default: i_out_ready <= ~i_out_ready;
                endcase
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_out_data.add_rejected) rejects_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_out_data.y_result, 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.y_result !== want.y_result)
                    report_mismatch("y_result", o_out_data.y_result, want.y_result);
                if (o_out_data.table_ready !== want.table_ready)
                    report_mismatch("table_ready", o_out_data.table_ready,
                                    want.table_ready);
                if (o_out_data.add_rejected !== want.add_rejected)
                    report_mismatch("add_rejected", o_out_data.add_rejected,
                                    want.add_rejected);
            end
        end
    end

    function automatic t_in make_req(logic [1:0] k, logic [31:0] x, logic [31:0] y);
        t_in r;
        r.kind    = k;
        r.x_value = x;
        r.y_value = y;
        return r;
    endfunction

    // Random x/y: mostly modest values, sometimes full range or extremes.
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 15) << 16;
            default: return 32'($signed($urandom_range(0, 2000)) - 1000) << 12;
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_requests.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_limits(logic [31:0] lo, logic [31:0] hi);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LOWER;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= CFG_UPPER;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        lim_lo = $signed(lo);
        lim_hi = $signed(hi);
    endtask

    // One random batch: table build-up with random content, converts, some noise.
    task automatic queue_random_batch(int count);
        int npts;
        for (int n = 0; n < count; ) begin
            pending_requests.push_back(make_req(KIND_CLEAR, $urandom(), $urandom()));
            n++;
            npts = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 19) :
                                                   $urandom_range(0, 6);
            for (int k = 0; k < npts; k++, n++)
                pending_requests.push_back(make_req(KIND_ADD, rand_value(), rand_value()));
            for (int k = $urandom_range(2, 12); k > 0; k--, n++) begin
                pending_requests.push_back(make_req(
                    ($urandom_range(0, 19) == 0) ? 2'd3 : KIND_CONVERT,
                    rand_value(), $urandom()));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_LOWER;
        i_cfg_data    = '0;
        hold_left     = 0;
        sender_paused = 1'b0;
        cal_count     = 0;
        lim_lo        = -(64'sd1 <<< 31);
        lim_hi        = (64'sd1 <<< 31) - 1;
        mismatch_count = 0;
        results_seen  = 0;
        converts_sent = 0;
        rejects_seen  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, single point, equal x, extremes, overflow, unknown kind.
        write_limits(32'h8000_0000, 32'h7FFF_FFFF);
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h0001_0000, 32'h0));
        pending_requests.push_back(make_req(KIND_ADD, 32'h0002_0000, 32'hFFFF_0000));
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h8000_0000, 32'h0));
        pending_requests.push_back(make_req(KIND_ADD, 32'h0002_0000, 32'h0005_0000));
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h0002_0000, 32'h0));
        pending_requests.push_back(make_req(KIND_ADD, 32'h8000_0000, 32'h8000_0000));
        pending_requests.push_back(make_req(KIND_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h7FFF_FFFF, 32'h0));
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h0001_8000, 32'h0));
        pending_requests.push_back(make_req(KIND_CONVERT, 32'hC000_0000, 32'h0));
        pending_requests.push_back(make_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_requests.push_back(make_req(KIND_CLEAR, 32'h0, 32'h0));
        // three points on one x: the first segment must be used
        pending_requests.push_back(make_req(KIND_ADD, 32'h0003_0000, 32'h0001_0000));
        pending_requests.push_back(make_req(KIND_ADD, 32'h0003_0000, 32'h0002_0000));
        pending_requests.push_back(make_req(KIND_ADD, 32'h0003_0000, 32'h0003_0000));
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h0003_0000, 32'h0));
        pending_requests.push_back(make_req(KIND_CLEAR, 32'h0, 32'h0));
        // steep segment, then far extrapolation saturates
        pending_requests.push_back(make_req(KIND_ADD, 32'h0, 32'h8000_0000));
        pending_requests.push_back(make_req(KIND_ADD, 32'h1, 32'h7FFF_FFFF));
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h7FFF_FFFF, 32'h0));
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h8000_0000, 32'h0));
        for (int k = 0; k < 15; k++)
            pending_requests.push_back(make_req(KIND_ADD, k << 16, k << 14));
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h0003_4000, 32'h0));
        wait_drained();

        // Crossed limits: lower is tested first.
        write_limits(32'h0001_0000, 32'hFFFF_0000);
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h0, 32'h0));
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h0009_0000, 32'h0));
        pending_requests.push_back(make_req(KIND_CLEAR, 32'h0, 32'h0));
        pending_requests.push_back(make_req(KIND_CONVERT, 32'h0, 32'h0));
        wait_drained();

        // Random phases under a few limit settings.
        write_limits(32'hFFF0_0000, 32'h0010_0000);
        queue_random_batch(250);
        // long receiver hold while requests keep coming
        wait (pending_requests.size() < 200);
        hold_left = LONG_HOLD;
        wait_drained();

        write_limits(32'h8000_0000, 32'h7FFF_FFFF);
        queue_random_batch(250);
        wait (pending_requests.size() < 100);
        // sender pause until every outstanding result is back
        sender_paused = 1'b1;
        while (i_in_valid || expected_results.size() != 0) @(posedge i_clk);
        sender_paused = 1'b0;
        wait_drained();

        write_limits($urandom(), $urandom());
        queue_random_batch(250);
        wait_drained();

        $display("Covered %0d results (%0d converts, %0d rejected adds), limit sets incl.",
                 results_seen, converts_sent, rejects_seen);
        $display("full range, narrow, crossed and random; long output hold and input pause.");
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/plc_pkg.sv
rtl/plc_ram.sv
rtl/plc_div.sv
rtl/plc_front.sv
rtl/plc_back.sv
rtl/piecewise_linear_converter.sv
rtl/plc_checker.sv
tb/piecewise_linear_converter_test.sv
